// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent check forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LBEC_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lbec: same-cycle check failed");

// next-cycle implication
`define LBEC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lbec: next-cycle check failed");

`endif

// ===== rtl/core/lbec_pkg.sv =====
// ----------------------------------------------------------------------------
// lbec_pkg
// widths, edge order, orientation codes and per-edge check record
// ----------------------------------------------------------------------------
package lbec_pkg;

	localparam int unsigned CoordW = 16;
	localparam int unsigned SizeW  = 16;
	localparam int unsigned DiffW  = CoordW + 2;
	localparam int unsigned CmpW   = DiffW + 1;
	localparam int unsigned ProdW  = DiffW + SizeW + 1;
	localparam int unsigned SumW   = ProdW + 1;
	localparam int unsigned EdgeN  = 4;
	localparam int unsigned MaskW  = EdgeN;

	localparam int unsigned EDGE_TOP    = 0;
	localparam int unsigned EDGE_RIGHT  = 1;
	localparam int unsigned EDGE_BOTTOM = 2;
	localparam int unsigned EDGE_LEFT   = 3;

	typedef enum logic [1:0] {
		ORI_COL = 2'd0,
		ORI_POS = 2'd1,
		ORI_NEG = 2'd2
	} ori_t;

	typedef struct packed {
		ori_t o3;
		ori_t o4;
		logic in1;
		logic in2;
		logic hit34;
	} edge_chk_t;

	typedef edge_chk_t [EdgeN-1:0] edge_chk_vec_t;

	function automatic ori_t ori_code(input logic zero, input logic neg);
		ori_t o;
		if (zero) begin
			o = ORI_COL;
		end else if (neg) begin
			o = ORI_NEG;
		end else begin
			o = ORI_POS;
		end
		return o;
	endfunction

	function automatic ori_t ori_flip(input ori_t o);
		ori_t r;
		case (o)
			ORI_POS: r = ORI_NEG;
			ORI_NEG: r = ORI_POS;
			default: r = ORI_COL;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/lbec_diff_stage.sv =====
// ----------------------------------------------------------------------------
// lbec_diff_stage
// first stage: start point relative to the box centre, in doubled units
// ----------------------------------------------------------------------------
module lbec_diff_stage (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [lbec_pkg::CoordW-1:0] start_x,
	input  logic signed [lbec_pkg::CoordW-1:0] start_y,
	input  logic signed [lbec_pkg::CoordW-1:0] center_x,
	input  logic signed [lbec_pkg::CoordW-1:0] center_y,
	input  logic        [lbec_pkg::SizeW-1:0]  box_width,
	input  logic        [lbec_pkg::SizeW-1:0]  box_height,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [lbec_pkg::DiffW-1:0]  dx,
	output logic signed [lbec_pkg::DiffW-1:0]  dy,
	output logic        [lbec_pkg::SizeW-1:0]  size_w,
	output logic        [lbec_pkg::SizeW-1:0]  size_h
);

	logic                              v_s1;
	logic signed [lbec_pkg::DiffW-1:0] dx_s1;
	logic signed [lbec_pkg::DiffW-1:0] dy_s1;
	logic        [lbec_pkg::SizeW-1:0] w_s1;
	logic        [lbec_pkg::SizeW-1:0] h_s1;

	logic signed [lbec_pkg::CoordW:0]  sub_x;
	logic signed [lbec_pkg::CoordW:0]  sub_y;

	assign sub_x = $signed({start_x[lbec_pkg::CoordW-1], start_x})
		- $signed({center_x[lbec_pkg::CoordW-1], center_x});
	assign sub_y = $signed({start_y[lbec_pkg::CoordW-1], start_y})
		- $signed({center_y[lbec_pkg::CoordW-1], center_y});

	assign in_ready = !v_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	// doubling makes the half sizes whole
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			dx_s1 <= $signed({sub_x, 1'b0});
			dy_s1 <= $signed({sub_y, 1'b0});
			w_s1  <= box_width;
			h_s1  <= box_height;
		end
	end

	assign out_valid = v_s1;
	assign dx        = dx_s1;
	assign dy        = dy_s1;
	assign size_w    = w_s1;
	assign size_h    = h_s1;

endmodule

// ===== rtl/core/lbec_prod_stage.sv =====
// ----------------------------------------------------------------------------
// lbec_prod_stage
// second stage: the two cross products and the per-edge compare terms
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lbec_prod_stage (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [lbec_pkg::DiffW-1:0]  dx,
	input  logic signed [lbec_pkg::DiffW-1:0]  dy,
	input  logic        [lbec_pkg::SizeW-1:0]  size_w,
	input  logic        [lbec_pkg::SizeW-1:0]  size_h,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [lbec_pkg::ProdW-1:0]  p1,
	output logic signed [lbec_pkg::ProdW-1:0]  p2,
	output lbec_pkg::edge_chk_vec_t            chk
);

	logic                              v_s2;
	logic signed [lbec_pkg::ProdW-1:0] p1_s2;
	logic signed [lbec_pkg::ProdW-1:0] p2_s2;
	lbec_pkg::edge_chk_vec_t           chk_s2;

	logic signed [lbec_pkg::ProdW-1:0] p1_c;
	logic signed [lbec_pkg::ProdW-1:0] p2_c;
	lbec_pkg::edge_chk_vec_t           chk_c;

	logic signed [lbec_pkg::ProdW-1:0] dx_e, dy_e, w_e, h_e;
	logic                              in_beat;

	logic signed [lbec_pkg::CmpW-1:0]  xs, ys, ws, hs, nws, nhs;
	logic                              wz, hz;
	logic                              inx_pw, inx_nw, iny_ph, iny_nh;
	logic                              xin, yin;
	logic                              o4z;
	logic [lbec_pkg::EdgeN-1:0]        o3z;

	assign dx_e = $signed({{(lbec_pkg::ProdW-lbec_pkg::DiffW){dx[lbec_pkg::DiffW-1]}}, dx});
	assign dy_e = $signed({{(lbec_pkg::ProdW-lbec_pkg::DiffW){dy[lbec_pkg::DiffW-1]}}, dy});
	assign w_e  = $signed({{(lbec_pkg::ProdW-lbec_pkg::SizeW){1'b0}}, size_w});
	assign h_e  = $signed({{(lbec_pkg::ProdW-lbec_pkg::SizeW){1'b0}}, size_h});

	// x*h and y*w, the only products any edge needs
	assign p1_c = dx_e * h_e;
	assign p2_c = dy_e * w_e;

	assign xs  = $signed({dx[lbec_pkg::DiffW-1], dx});
	assign ys  = $signed({dy[lbec_pkg::DiffW-1], dy});
	assign ws  = $signed({{(lbec_pkg::CmpW-lbec_pkg::SizeW){1'b0}}, size_w});
	assign hs  = $signed({{(lbec_pkg::CmpW-lbec_pkg::SizeW){1'b0}}, size_h});
	assign nws = -ws;
	assign nhs = -hs;
	assign wz  = (size_w == '0);
	assign hz  = (size_h == '0);

	// corner inside the box spanned by start and centre
	assign inx_pw = (xs >= ws) || wz;
	assign inx_nw = (xs <= nws) || wz;
	assign iny_ph = (ys >= hs) || hz;
	assign iny_nh = (ys <= nhs) || hz;
	assign xin    = (xs >= nws) && (xs <= ws);
	assign yin    = (ys >= nhs) && (ys <= hs);
	assign o4z    = wz || hz;

	assign o3z[lbec_pkg::EDGE_TOP]    = wz || (ys == hs);
	assign o3z[lbec_pkg::EDGE_RIGHT]  = hz || (xs == ws);
	assign o3z[lbec_pkg::EDGE_BOTTOM] = wz || (ys == nhs);
	assign o3z[lbec_pkg::EDGE_LEFT]   = hz || (xs == nws);

	always_comb begin
		chk_c[lbec_pkg::EDGE_TOP].o3 =
			lbec_pkg::ori_code(o3z[lbec_pkg::EDGE_TOP], ys > hs);
		chk_c[lbec_pkg::EDGE_TOP].o4 = lbec_pkg::ori_code(o4z, 1'b0);
		chk_c[lbec_pkg::EDGE_TOP].in1 = inx_nw && iny_ph;
		chk_c[lbec_pkg::EDGE_TOP].in2 = inx_pw && iny_ph;
		chk_c[lbec_pkg::EDGE_TOP].hit34 =
			(o3z[lbec_pkg::EDGE_TOP] && xin && (ys == hs)) || hz;

		chk_c[lbec_pkg::EDGE_RIGHT].o3 =
			lbec_pkg::ori_code(o3z[lbec_pkg::EDGE_RIGHT], xs > ws);
		chk_c[lbec_pkg::EDGE_RIGHT].o4 = lbec_pkg::ori_code(o4z, 1'b0);
		chk_c[lbec_pkg::EDGE_RIGHT].in1 = inx_pw && iny_ph;
		chk_c[lbec_pkg::EDGE_RIGHT].in2 = inx_pw && iny_nh;
		chk_c[lbec_pkg::EDGE_RIGHT].hit34 =
			(o3z[lbec_pkg::EDGE_RIGHT] && (xs == ws) && yin) || wz;

		chk_c[lbec_pkg::EDGE_BOTTOM].o3 =
			lbec_pkg::ori_code(o3z[lbec_pkg::EDGE_BOTTOM], ys > nhs);
		chk_c[lbec_pkg::EDGE_BOTTOM].o4 = lbec_pkg::ori_code(o4z, 1'b1);
		chk_c[lbec_pkg::EDGE_BOTTOM].in1 = inx_nw && iny_nh;
		chk_c[lbec_pkg::EDGE_BOTTOM].in2 = inx_pw && iny_nh;
		chk_c[lbec_pkg::EDGE_BOTTOM].hit34 =
			(o3z[lbec_pkg::EDGE_BOTTOM] && (ys == nhs) && xin) || hz;

		chk_c[lbec_pkg::EDGE_LEFT].o3 =
			lbec_pkg::ori_code(o3z[lbec_pkg::EDGE_LEFT], xs > nws);
		chk_c[lbec_pkg::EDGE_LEFT].o4 = lbec_pkg::ori_code(o4z, 1'b1);
		chk_c[lbec_pkg::EDGE_LEFT].in1 = inx_nw && iny_ph;
		chk_c[lbec_pkg::EDGE_LEFT].in2 = inx_nw && iny_nh;
		chk_c[lbec_pkg::EDGE_LEFT].hit34 =
			(o3z[lbec_pkg::EDGE_LEFT] && (xs == nws) && yin) || wz;
	end

	assign in_ready = !v_s2 || out_ready;
	assign in_beat  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (in_ready) begin
			v_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			p1_s2  <= p1_c;
			p2_s2  <= p2_c;
			chk_s2 <= chk_c;
		end
	end

	assign out_valid = v_s2;
	assign p1        = p1_s2;
	assign p2        = p2_s2;
	assign chk       = chk_s2;

	`LBEC_ASSERT_NEXT(a_zero_vec_zero_prod, (in_beat && {dx, dy} == '0), ({p1_s2, p2_s2} == '0))

endmodule

// ===== rtl/core/lbec_mask_stage.sv =====
// ----------------------------------------------------------------------------
// lbec_mask_stage
// third stage: product signs, orientation compare and the edge mask register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lbec_mask_stage (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [lbec_pkg::ProdW-1:0]  p1,
	input  logic signed [lbec_pkg::ProdW-1:0]  p2,
	input  lbec_pkg::edge_chk_vec_t            chk,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic        [lbec_pkg::MaskW-1:0]  edge_mask
);

	logic                              v_s3;
	logic        [lbec_pkg::MaskW-1:0] mask_s3;

	logic signed [lbec_pkg::SumW-1:0]  sum_v;
	logic signed [lbec_pkg::SumW-1:0]  dif_v;
	lbec_pkg::ori_t                    so, dn;
	lbec_pkg::ori_t                    o1 [lbec_pkg::EdgeN];
	lbec_pkg::ori_t                    o2 [lbec_pkg::EdgeN];
	logic        [lbec_pkg::MaskW-1:0] hit;
	logic        [lbec_pkg::MaskW-1:0] hit34_vec;
	logic                              in_beat;

	assign sum_v = $signed({p1[lbec_pkg::ProdW-1], p1}) + $signed({p2[lbec_pkg::ProdW-1], p2});
	assign dif_v = $signed({p1[lbec_pkg::ProdW-1], p1}) - $signed({p2[lbec_pkg::ProdW-1], p2});
	assign so    = lbec_pkg::ori_code(sum_v == '0, sum_v[lbec_pkg::SumW-1]);
	assign dn    = lbec_pkg::ori_code(dif_v == '0, dif_v[lbec_pkg::SumW-1]);

	// orientation of each edge end seen from the segment
	assign o1[lbec_pkg::EDGE_TOP]    = so;
	assign o2[lbec_pkg::EDGE_TOP]    = dn;
	assign o1[lbec_pkg::EDGE_RIGHT]  = dn;
	assign o2[lbec_pkg::EDGE_RIGHT]  = lbec_pkg::ori_flip(so);
	assign o1[lbec_pkg::EDGE_BOTTOM] = lbec_pkg::ori_flip(dn);
	assign o2[lbec_pkg::EDGE_BOTTOM] = lbec_pkg::ori_flip(so);
	assign o1[lbec_pkg::EDGE_LEFT]   = so;
	assign o2[lbec_pkg::EDGE_LEFT]   = lbec_pkg::ori_flip(dn);

	always_comb begin
		for (int e = 0; e < lbec_pkg::EdgeN; e++) begin
			hit[e] = ((o1[e] != o2[e]) && (chk[e].o3 != chk[e].o4))
				|| ((o1[e] == lbec_pkg::ORI_COL) && chk[e].in1)
				|| ((o2[e] == lbec_pkg::ORI_COL) && chk[e].in2)
				|| chk[e].hit34;
			hit34_vec[e] = chk[e].hit34;
		end
	end

	assign in_ready = !v_s3 || out_ready;
	assign in_beat  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (in_ready) begin
			v_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			mask_s3 <= hit;
		end
	end

	assign out_valid = v_s3;
	assign edge_mask = mask_s3;

	`LBEC_ASSERT_NEXT(a_touch_kept, in_beat, ((mask_s3 & $past(hit34_vec)) == $past(hit34_vec)))

endmodule

// ===== rtl/core/line_box_edge_crossing_mask_unit.sv =====
// ----------------------------------------------------------------------------
// line_box_edge_crossing_mask_unit
// segment from start point to box centre tested against the four box edges
//
//   channel  signals                                      direction
//   in       in_valid in_ready start_x start_y center_x   into block
//            center_y box_width box_height
//   out      out_valid out_ready edge_mask                out of block
//
// one beat per cycle while out_ready is high; beats pass through the
// subtract, multiply and add/sign register stages
// arst_n clears the stage valid bits only; data registers are not reset
// each stage holds while the next is full, in_ready is high whenever any
// stage is empty or the output beat is being taken
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module line_box_edge_crossing_mask_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [lbec_pkg::CoordW-1:0] start_x,
	input  logic signed [lbec_pkg::CoordW-1:0] start_y,
	input  logic signed [lbec_pkg::CoordW-1:0] center_x,
	input  logic signed [lbec_pkg::CoordW-1:0] center_y,
	input  logic        [lbec_pkg::SizeW-1:0]  box_width,
	input  logic        [lbec_pkg::SizeW-1:0]  box_height,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic        [lbec_pkg::MaskW-1:0]  edge_mask
);

	logic                              v1, r1;
	logic                              v2, r2;
	logic signed [lbec_pkg::DiffW-1:0] dx, dy;
	logic        [lbec_pkg::SizeW-1:0] size_w, size_h;
	logic signed [lbec_pkg::ProdW-1:0] p1, p2;
	lbec_pkg::edge_chk_vec_t           chk;

	lbec_diff_stage u_diff (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.start_x    (start_x),
		.start_y    (start_y),
		.center_x   (center_x),
		.center_y   (center_y),
		.box_width  (box_width),
		.box_height (box_height),
		.out_valid  (v1),
		.out_ready  (r1),
		.dx         (dx),
		.dy         (dy),
		.size_w     (size_w),
		.size_h     (size_h)
	);

	lbec_prod_stage u_prod (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v1),
		.in_ready  (r1),
		.dx        (dx),
		.dy        (dy),
		.size_w    (size_w),
		.size_h    (size_h),
		.out_valid (v2),
		.out_ready (r2),
		.p1        (p1),
		.p2        (p2),
		.chk       (chk)
	);

	lbec_mask_stage u_mask (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v2),
		.in_ready  (r2),
		.p1        (p1),
		.p2        (p2),
		.chk       (chk),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.edge_mask (edge_mask)
	);

	`LBEC_ASSERT_IMPL(a_no_idle_stall, (!v1 || !v2 || !out_valid || out_ready), in_ready)

	`LBEC_ASSERT_NEXT(a_out_after_handoff, (v2 && r2), out_valid)

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the line/box edge crossing mask unit: a short
// table of hand-picked queries, then random segment and box beats, each
// result checked in order against its typed mask or, where none is typed,
// a behavioural mask calculation, under random gaps on the input side and
// random back-pressure on the output
module tb;
	import lbec_pkg::*;

	localparam int RAND_N = 1800;
	localparam int LIMIT  = 600000;
	localparam int DIR_N  = 22;

	typedef struct packed {
		logic signed [CoordW-1:0] sx;
		logic signed [CoordW-1:0] sy;
		logic signed [CoordW-1:0] cx;
		logic signed [CoordW-1:0] cy;
		logic        [SizeW-1:0]  w;
		logic        [SizeW-1:0]  h;
	} box_query_t;

	typedef struct packed {
		box_query_t           q;
		logic                 given;
		logic [MaskW-1:0]     mask;
	} dir_row_t;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic signed [CoordW-1:0] start_x;
	logic signed [CoordW-1:0] start_y;
	logic signed [CoordW-1:0] center_x;
	logic signed [CoordW-1:0] center_y;
	logic        [SizeW-1:0]  box_width;
	logic        [SizeW-1:0]  box_height;
	logic                     out_valid;
	logic                     out_ready;
	logic        [MaskW-1:0]  edge_mask;

	logic                     mask_given;
	logic        [MaskW-1:0]  mask_typed;
	logic        [MaskW-1:0]  pending_masks [$];
	int                       mismatches = 0;
	int                       taken = 0;
	int                       cycles = 0;
	bit                       held = 1'b0;
	box_query_t               seen;
	logic        [MaskW-1:0]  want;

	// start, centre, width, height, typed flag, typed mask
	dir_row_t dir_rows [DIR_N] = '{
		'{'{0, 0, 0, 0, 0, 0}, 1'b1, 4'hF},
		'{'{-100, 0, 0, 0, 20, 10}, 1'b1, 4'h8},
		'{'{100, 0, 0, 0, 20, 10}, 1'b1, 4'h2},
		'{'{0, 100, 0, 0, 20, 10}, 1'b1, 4'h1},
		'{'{0, -100, 0, 0, 20, 10}, 1'b1, 4'h4},
		'{'{0, 0, 0, 0, 2, 2}, 1'b1, 4'h0},
		'{'{-10, 5, 0, 0, 20, 10}, 1'b1, 4'h9},
		'{'{0, 5, 0, 0, 20, 10}, 1'b1, 4'h1},
		'{'{-100, 0, 0, 0, 20, 0}, 1'b1, 4'hD},
		'{'{0, -100, 0, 0, 0, 20}, 1'b1, 4'hE},
		'{'{-20, -10, 0, 0, 20, 10}, 1'b1, 4'hC},
		'{'{32767, 32767, 32767, 32767, 0, 65535}, 1'b1, 4'hA},
		'{'{-32768, -32768, 32767, 32767, 65535, 65535}, 1'b1, 4'hC},
		'{'{32767, -32768, -32768, 32767, 65535, 65535}, 1'b0, 4'h0},
		'{'{-32768, 32767, 32767, -32768, 0, 0}, 1'b1, 4'hF},
		'{'{12345, -32768, -32768, -32768, 65535, 1}, 1'b0, 4'h0},
		'{'{-1, -1, 1, 1, 1, 1}, 1'b0, 4'h0},
		'{'{5, 0, 0, 0, 10, 0}, 1'b1, 4'h7},
		'{'{32767, 0, -32768, 0, 65535, 0}, 1'b0, 4'h0},
		'{'{0, 32767, 0, -32768, 0, 65535}, 1'b0, 4'h0},
		'{'{-32768, -32768, -32768, -32768, 65535, 65535}, 1'b1, 4'h0},
		'{'{3, 7, 3, 7, 0, 0}, 1'b1, 4'hF}
	};

	line_box_edge_crossing_mask_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.start_x    (start_x),
		.start_y    (start_y),
		.center_x   (center_x),
		.center_y   (center_y),
		.box_width  (box_width),
		.box_height (box_height),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.edge_mask  (edge_mask)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic ori_t turn(longint px, longint py, longint qx, longint qy,
			longint rx, longint ry);
		longint v;
		v = (qy - py) * (rx - qx) - (qx - px) * (ry - qy);
		if (v == 0) begin
			return ORI_COL;
		end else if (v > 0) begin
			return ORI_POS;
		end
		return ORI_NEG;
	endfunction

	// q inside the bounding box of p and r, ends included
	function automatic bit in_span(longint px, longint py, longint qx, longint qy,
			longint rx, longint ry);
		return qx <= ((px > rx) ? px : rx) && qx >= ((px < rx) ? px : rx) &&
			qy <= ((py > ry) ? py : ry) && qy >= ((py < ry) ? py : ry);
	endfunction

	function automatic bit edge_crossed(longint ax, longint ay, longint bx, longint by_,
			longint ex0, longint ey0, longint ex1, longint ey1);
		ori_t o1, o2, o3, o4;
		o1 = turn(ax, ay, bx, by_, ex0, ey0);
		o2 = turn(ax, ay, bx, by_, ex1, ey1);
		o3 = turn(ex0, ey0, ex1, ey1, ax, ay);
		o4 = turn(ex0, ey0, ex1, ey1, bx, by_);
		if (o1 != o2 && o3 != o4) return 1'b1;
		if (o1 == ORI_COL && in_span(ax, ay, ex0, ey0, bx, by_)) return 1'b1;
		if (o2 == ORI_COL && in_span(ax, ay, ex1, ey1, bx, by_)) return 1'b1;
		if (o3 == ORI_COL && in_span(ex0, ey0, ax, ay, ex1, ey1)) return 1'b1;
		if (o4 == ORI_COL && in_span(ex0, ey0, bx, by_, ex1, ey1)) return 1'b1;
		return 1'b0;
	endfunction

	// everything doubled so the half sizes land on whole numbers
	function automatic logic [MaskW-1:0] crossing_mask(box_query_t qr);
		longint sx, sy, cx, cy, lft, rgt, topy, boty;
		logic [MaskW-1:0] m;
		sx   = 2 * longint'($signed(qr.sx));
		sy   = 2 * longint'($signed(qr.sy));
		cx   = 2 * longint'($signed(qr.cx));
		cy   = 2 * longint'($signed(qr.cy));
		lft  = cx - longint'(qr.w);
		rgt  = cx + longint'(qr.w);
		topy = cy + longint'(qr.h);
		boty = cy - longint'(qr.h);
		m = '0;
		m[EDGE_TOP]    = edge_crossed(sx, sy, cx, cy, lft, topy, rgt, topy);
		m[EDGE_RIGHT]  = edge_crossed(sx, sy, cx, cy, rgt, topy, rgt, boty);
		m[EDGE_BOTTOM] = edge_crossed(sx, sy, cx, cy, lft, boty, rgt, boty);
		m[EDGE_LEFT]   = edge_crossed(sx, sy, cx, cy, lft, topy, lft, boty);
		return m;
	endfunction

	function automatic int idle_len();
		int r;
		r = int'($urandom_range(99));
		if (r < 55) return 0;
		if (r < 93) return int'($urandom_range(3, 1));
		return int'($urandom_range(30, 8));
	endfunction

	function automatic int near(int base, int span);
		return base + int'($urandom_range(2 * span)) - span;
	endfunction

	function automatic int extreme_coord();
		case ($urandom_range(4))
			0: return -32768;
			1: return -1;
			2: return 0;
			3: return 1;
			default: return 32767;
		endcase
	endfunction

	function automatic int extreme_size();
		case ($urandom_range(3))
			0: return 0;
			1: return 1;
			2: return 65534;
			default: return 65535;
		endcase
	endfunction

	task automatic make_query(output box_query_t qr);
		int kind, ox, oy;
		kind = int'($urandom_range(99));
		ox = int'($urandom_range(64000)) - 32000;
		oy = int'($urandom_range(64000)) - 32000;
		qr.cx = CoordW'(ox);
		qr.cy = CoordW'(oy);
		qr.w  = SizeW'($urandom_range(40));
		qr.h  = SizeW'($urandom_range(40));
		if ($urandom_range(7) == 0) qr.w = '0;
		if ($urandom_range(7) == 0) qr.h = '0;
		qr.sx = CoordW'(near(ox, 80));
		qr.sy = CoordW'(near(oy, 80));
		if (kind < 25) begin
			qr = box_query_t'({$urandom(), $urandom(), $urandom()});
		end else if (kind < 35) begin
			qr.sx = qr.cx;
			qr.sy = qr.cy;
		end else if (kind < 55) begin
			// start placed on an edge line, sometimes on a corner
			qr.w = SizeW'(2 * $urandom_range(20));
			qr.h = SizeW'(2 * $urandom_range(20));
			case ($urandom_range(3))
				EDGE_TOP:    qr.sy = CoordW'(oy + int'(qr.h) / 2);
				EDGE_RIGHT:  qr.sx = CoordW'(ox + int'(qr.w) / 2);
				EDGE_BOTTOM: qr.sy = CoordW'(oy - int'(qr.h) / 2);
				default:     qr.sx = CoordW'(ox - int'(qr.w) / 2);
			endcase
			if ($urandom_range(3) == 0) begin
				qr.sx = CoordW'($urandom_range(1) ? ox + int'(qr.w) / 2 : ox - int'(qr.w) / 2);
				qr.sy = CoordW'($urandom_range(1) ? oy + int'(qr.h) / 2 : oy - int'(qr.h) / 2);
			end
		end else if (kind < 70) begin
			if ($urandom_range(1)) begin
				qr.sy = qr.cy;
			end else begin
				qr.sx = qr.cx;
			end
		end else if (kind < 80) begin
			qr.sx = CoordW'(extreme_coord());
			qr.sy = CoordW'(extreme_coord());
			qr.cx = CoordW'(extreme_coord());
			qr.cy = CoordW'(extreme_coord());
			qr.w  = SizeW'(extreme_size());
			qr.h  = SizeW'(extreme_size());
		end
	endtask

	task automatic offer(box_query_t qr, logic given, logic [MaskW-1:0] mask, int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		start_x    <= qr.sx;
		start_y    <= qr.sy;
		center_x   <= qr.cx;
		center_y   <= qr.cy;
		box_width  <= qr.w;
		box_height <= qr.h;
		mask_given <= given;
		mask_typed <= mask;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic report(string what, logic [MaskW-1:0] got, logic [MaskW-1:0] exp_mask);
		if (mismatches < 50) begin
			$display("mismatch %s: edge_mask %h, wanted %h", what, got, exp_mask);
		end
		mismatches++;
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	// input beats queue a predicted mask, output beats are checked in order
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				seen = '{start_x, start_y, center_x, center_y, box_width, box_height};
				pending_masks.push_back(mask_given ? mask_typed : crossing_mask(seen));
				taken++;
			end
			if (out_valid && out_ready) begin
				if (pending_masks.size() == 0) begin
					report("beat with nothing pending", edge_mask, 'x);
				end else begin
					want = pending_masks.pop_front();
					if (edge_mask !== want) report("on result beat", edge_mask, want);
				end
			end
		end
	end

	// output back-pressure, with one long hold once the stream is under way
	initial begin
		int stall, run;
		out_ready <= 1'b0;
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			if (!held && taken >= 600) begin
				stall = 400;
				held  = 1'b1;
			end else begin
				stall = idle_len();
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			run = ($urandom_range(9) == 0) ? int'($urandom_range(120, 40))
				: int'($urandom_range(6, 1));
			out_ready <= 1'b1;
			repeat (run) @(posedge clk);
		end
	end

	initial begin
		box_query_t qr;
		int gap;
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		start_x    <= '0;
		start_y    <= '0;
		center_x   <= '0;
		center_y   <= '0;
		box_width  <= '0;
		box_height <= '0;
		mask_given <= 1'b0;
		mask_typed <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < DIR_N; i++) begin
			offer(dir_rows[i].q, dir_rows[i].given, dir_rows[i].mask, idle_len());
		end
		for (int n = 0; n < RAND_N; n++) begin
			make_query(qr);
			gap = ((n / 150) % 3 == 0) ? 0 : idle_len();
			offer(qr, 1'b0, '0, gap);
		end
		in_valid <= 1'b0;
		// let the last accepted beat reach the queue first
		@(posedge clk);
		while (pending_masks.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule
